### rtl/tthf_pkg.sv
// tthf_pkg: types and constants of the target track hysteresis filter
// depends on nothing; imported by target_track_hysteresis_filter, tthf_track_checker and the testbench
package tthf_pkg;

    // run counters saturate here
    localparam int RUN_COUNT_MAX = 255;
    localparam int RUN_W         = $clog2(RUN_COUNT_MAX + 1);
    localparam int SWC_W         = 8;
    localparam int CMP_W         = (RUN_W > SWC_W) ? RUN_W : SWC_W;

    localparam int HISTORY_DEPTH = 3;

    localparam int POS_W  = 16;
    localparam int ID_W   = 16;
    localparam int THR_W  = 16;
    localparam int MAG_W  = POS_W;              // |a - b| of two 16 bit values
    localparam int SQ_W   = 2 * MAG_W;
    localparam int ACC_W  = SQ_W + 2;           // sum of three squares
    localparam int ROOT_W = ACC_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int SQRT_STEPS = ACC_W / 2;
    localparam int ITER_W = $clog2(SQRT_STEPS);
    localparam int SQ_STEPS = 8;                // 6 axis terms plus the drain of the r_mag and r_sq registers
    localparam int STEP_W = $clog2(SQ_STEPS);

    // configuration register indexes
    localparam logic [1:0] CFG_FAST_SWITCH = 2'd0;
    localparam logic [1:0] CFG_SLOW_SWITCH = 2'd1;
    localparam logic [1:0] CFG_STABLE_THR  = 2'd2;

    localparam logic [SWC_W-1:0] FAST_SWITCH_RST = 8'd2;
    localparam logic [SWC_W-1:0] SLOW_SWITCH_RST = 8'd4;
    localparam logic [THR_W-1:0] STABLE_THR_RST  = 16'd100;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_MULTI  = 2'd2
    } t_mode;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_END  = 5'b00010,
        ST_SQ   = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_WAIT = 5'b10000
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef struct packed {
        logic [ID_W-1:0] id;
        t_pos            pos;
    } t_box;

endpackage

### rtl/target_track_hysteresis_filter.sv
// target_track_hysteresis_filter: top level, frame target mode, tracking and stability
// depends on tthf_pkg
//
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+----------------------------------------
// in      | input     | i_in_valid / o_in_ready    | box_present, box_id, pos_x/y/z, frame_last
// out     | output    | o_out_valid / i_out_ready  | target_mode, target_id, target_x/y/z,
//         |           |                            | position_stable
// cfg     | input     | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
//
// an item that does not end a frame is taken in ST_IDLE, which the block does not leave
// a frame end passes ST_END (mode, track and history update) and then ST_WAIT; once
// the history holds three positions, ST_SQ (the squaring multiplier) and ST_ROOT (the
// two bit-serial square root units, two radicand bits each cycle) come between them
// reset is synchronous and active low; config registers come up 2, 4 and 100
// the result waits in an output register; boxes of the next frame are taken
// while it stalls, a frame end then holds until the register frees
module target_track_hysteresis_filter
    import tthf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input items
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_box_present,
    input  logic [ID_W-1:0]         i_box_id,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic                    i_frame_last,
    // result items
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_target_mode,
    output logic [ID_W-1:0]         o_target_id,
    output logic signed [POS_W-1:0] o_target_x,
    output logic signed [POS_W-1:0] o_target_y,
    output logic signed [POS_W-1:0] o_target_z,
    output logic                    o_position_stable,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [THR_W-1:0]        i_cfg_data
);

    // control state
    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [RUN_W-1:0]    r_run_none, n_run_none;
    logic [RUN_W-1:0]    r_run_single, n_run_single;
    logic [RUN_W-1:0]    r_run_multi, n_run_multi;
    logic [1:0]          r_cnt, n_cnt;          // boxes this frame, saturates at two
    logic                r_prev, n_prev;        // tracked id seen this frame
    logic [1:0]          r_fill, n_fill;
    logic                r_full, n_full;        // stability check runs for this frame
    logic [STEP_W-1:0]   r_step, n_step;
    logic [ITER_W-1:0]   r_iter, n_iter;
    logic                r_ov, n_ov;
    logic                w_load;

    // config
    logic [SWC_W-1:0]    r_fast;
    logic [SWC_W-1:0]    r_slow;
    logic [THR_W-1:0]    r_thr;

    // payload
    t_box                r_trk, n_trk;
    t_box                r_cand, n_cand;
    t_pos                r_hist [HISTORY_DEPTH];
    t_pos                n_hist [HISTORY_DEPTH];
    logic [MAG_W-1:0]    r_mag, n_mag;
    logic [SQ_W-1:0]     r_sq;
    logic [ACC_W-1:0]    r_acc [2];
    logic [ACC_W-1:0]    n_acc [2];
    logic [REM_W-1:0]    r_rem [2];
    logic [REM_W-1:0]    n_rem [2];
    logic [ROOT_W-1:0]   r_root [2];
    logic [ROOT_W-1:0]   n_root [2];

    t_mode               r_out_mode;
    t_box                r_out_box;
    logic                r_out_stable;

    // frame end helpers
    logic                w_in_acc;
    t_box                w_box;
    logic [CMP_W-1:0]    w_none_c, w_single_c, w_multi_c, w_fast_c, w_slow_c;
    logic signed [POS_W:0] w_a, w_b, w_diff;
    logic [REM_W+1:0]    w_rem_sh [2];
    logic [REM_W+1:0]    w_trial [2];
    logic [ROOT_W:0]     w_sum;
    logic [ROOT_W:0]     w_thr2;
    logic                w_stable;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && (r_state == ST_IDLE);

    assign w_box.id    = i_box_id;
    assign w_box.pos.x = i_pos_x;
    assign w_box.pos.y = i_pos_y;
    assign w_box.pos.z = i_pos_z;

    // mean below threshold is sum below twice the threshold
    assign w_sum    = {1'b0, r_root[0]} + {1'b0, r_root[1]};
    assign w_thr2   = (ROOT_W + 1)'({r_thr, 1'b0});
    assign w_stable = r_full && (w_sum != '0) && (w_sum < w_thr2);
    assign w_load   = (r_state == ST_WAIT) && (!r_ov || i_out_ready);

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_run_none   = r_run_none;
        n_run_single = r_run_single;
        n_run_multi  = r_run_multi;
        n_cnt        = r_cnt;
        n_prev       = r_prev;
        n_fill       = r_fill;
        n_full       = r_full;
        n_step       = r_step;
        n_iter       = r_iter;
        n_trk        = r_trk;
        n_cand       = r_cand;
        n_hist       = r_hist;
        n_mag        = '0;
        n_acc        = r_acc;
        n_rem        = r_rem;
        n_root       = r_root;
        n_ov         = r_ov && !i_out_ready;
        w_a          = '0;
        w_b          = '0;
        w_none_c     = '0;
        w_single_c   = '0;
        w_multi_c    = '0;
        w_fast_c     = CMP_W'(r_fast);
        w_slow_c     = CMP_W'(r_slow);
        for (int u = 0; u < 2; u++) begin
            w_rem_sh[u] = {r_rem[u], r_acc[u][ACC_W-1 -: 2]};
            w_trial[u]  = (REM_W + 2)'({r_root[u], 2'b01});
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_box_present) begin
                        // follow the previous id, else the smallest id, first one on ties
                        if (!r_prev) begin
                            if (i_box_id == r_trk.id) begin
                                n_cand = w_box;
                                n_prev = 1'b1;
                            end else if (r_cnt == 2'd0 || i_box_id < r_cand.id) begin
                                n_cand = w_box;
                            end
                        end
                        if (r_cnt != 2'd2) begin
                            n_cnt = r_cnt + 2'd1;
                        end
                    end
                    if (i_frame_last) begin
                        n_state = ST_END;
                    end
                end
            end
            ST_END: begin
                // saturating run counters
                n_run_none   = '0;
                n_run_single = '0;
                n_run_multi  = '0;
                case (r_cnt)
                    2'd0: n_run_none = (r_run_none >= RUN_W'(RUN_COUNT_MAX)) ?
                                       RUN_W'(RUN_COUNT_MAX) : r_run_none + 1'b1;
                    2'd1: n_run_single = (r_run_single >= RUN_W'(RUN_COUNT_MAX)) ?
                                         RUN_W'(RUN_COUNT_MAX) : r_run_single + 1'b1;
                    default: n_run_multi = (r_run_multi >= RUN_W'(RUN_COUNT_MAX)) ?
                                           RUN_W'(RUN_COUNT_MAX) : r_run_multi + 1'b1;
                endcase
                w_none_c   = CMP_W'(n_run_none);
                w_single_c = CMP_W'(n_run_single);
                w_multi_c  = CMP_W'(n_run_multi);

                // hysteresis: fast count to leave no target, slow count otherwise
                case (r_mode)
                    MODE_NONE: begin
                        if (w_single_c >= w_fast_c) begin
                            n_mode = MODE_SINGLE;
                        end else if (w_multi_c >= w_fast_c) begin
                            n_mode = MODE_MULTI;
                        end
                    end
                    MODE_SINGLE: begin
                        if (w_none_c >= w_slow_c) begin
                            n_mode = MODE_NONE;
                        end else if (w_multi_c >= w_slow_c) begin
                            n_mode = MODE_MULTI;
                        end
                    end
                    default: begin
                        if (w_single_c >= w_slow_c) begin
                            n_mode = MODE_SINGLE;
                        end else if (w_none_c >= w_slow_c) begin
                            n_mode = MODE_NONE;
                        end
                    end
                endcase

                if (r_cnt != 2'd0) begin
                    n_trk = r_cand;
                end

                // position history, oldest at index 0
                if (r_fill == 2'(HISTORY_DEPTH)) begin
                    for (int h = 0; h < HISTORY_DEPTH - 1; h++) begin
                        n_hist[h] = r_hist[h + 1];
                    end
                    n_hist[HISTORY_DEPTH - 1] = n_trk.pos;
                    n_full = 1'b1;
                end else begin
                    n_hist[r_fill] = n_trk.pos;
                    n_fill = r_fill + 2'd1;
                    n_full = (r_fill == 2'(HISTORY_DEPTH - 1));
                end

                n_cnt  = 2'd0;
                n_prev = 1'b0;
                n_step = '0;
                n_iter = '0;
                for (int u = 0; u < 2; u++) begin
                    n_acc[u]  = '0;
                    n_rem[u]  = '0;
                    n_root[u] = '0;
                end
                n_state = n_full ? ST_SQ : ST_WAIT;
            end
            ST_SQ: begin
                // stage 1: |newest - older| per axis; stage 2 squares; stage 3 sums
                case (r_step)
                    3'd0: begin w_a = {r_hist[2].x[POS_W-1], r_hist[2].x};
                                w_b = {r_hist[0].x[POS_W-1], r_hist[0].x}; end
                    3'd1: begin w_a = {r_hist[2].y[POS_W-1], r_hist[2].y};
                                w_b = {r_hist[0].y[POS_W-1], r_hist[0].y}; end
                    3'd2: begin w_a = {r_hist[2].z[POS_W-1], r_hist[2].z};
                                w_b = {r_hist[0].z[POS_W-1], r_hist[0].z}; end
                    3'd3: begin w_a = {r_hist[2].x[POS_W-1], r_hist[2].x};
                                w_b = {r_hist[1].x[POS_W-1], r_hist[1].x}; end
                    3'd4: begin w_a = {r_hist[2].y[POS_W-1], r_hist[2].y};
                                w_b = {r_hist[1].y[POS_W-1], r_hist[1].y}; end
                    3'd5: begin w_a = {r_hist[2].z[POS_W-1], r_hist[2].z};
                                w_b = {r_hist[1].z[POS_W-1], r_hist[1].z}; end
                    default: begin w_a = '0; w_b = '0; end
                endcase
                n_mag = w_diff[POS_W] ? MAG_W'(-w_diff) : MAG_W'(w_diff);
                if (r_step >= 3'd2 && r_step <= 3'd4) begin
                    n_acc[0] = r_acc[0] + ACC_W'(r_sq);
                end else if (r_step >= 3'd5) begin
                    n_acc[1] = r_acc[1] + ACC_W'(r_sq);
                end
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(SQ_STEPS - 1)) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                // restoring square root, one result bit per cycle per unit
                for (int u = 0; u < 2; u++) begin
                    n_acc[u] = {r_acc[u][ACC_W-3:0], 2'b00};
                    if (w_rem_sh[u] >= w_trial[u]) begin
                        n_rem[u]  = REM_W'(w_rem_sh[u] - w_trial[u]);
                        n_root[u] = {r_root[u][ROOT_W-2:0], 1'b1};
                    end else begin
                        n_rem[u]  = REM_W'(w_rem_sh[u]);
                        n_root[u] = {r_root[u][ROOT_W-2:0], 1'b0};
                    end
                end
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_diff = w_a - w_b;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= MODE_NONE;
            r_run_none   <= '0;
            r_run_single <= '0;
            r_run_multi  <= '0;
            r_cnt        <= '0;
            r_prev       <= 1'b0;
            r_fill       <= '0;
            r_full       <= 1'b0;
            r_step       <= '0;
            r_iter       <= '0;
            r_ov         <= 1'b0;
            r_trk        <= '0;
            r_fast       <= FAST_SWITCH_RST;
            r_slow       <= SLOW_SWITCH_RST;
            r_thr        <= STABLE_THR_RST;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_run_none   <= n_run_none;
            r_run_single <= n_run_single;
            r_run_multi  <= n_run_multi;
            r_cnt        <= n_cnt;
            r_prev       <= n_prev;
            r_fill       <= n_fill;
            r_full       <= n_full;
            r_step       <= n_step;
            r_iter       <= n_iter;
            r_ov         <= n_ov;
            r_trk        <= n_trk;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FAST_SWITCH: r_fast <= i_cfg_data[SWC_W-1:0];
                    CFG_SLOW_SWITCH: r_slow <= i_cfg_data[SWC_W-1:0];
                    CFG_STABLE_THR:  r_thr  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_hist <= n_hist;
        r_mag  <= n_mag;
        r_sq   <= r_mag * r_mag;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_root <= n_root;
        if (w_load) begin
            r_out_mode   <= r_mode;
            r_out_box    <= r_trk;
            r_out_stable <= w_stable;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_target_mode     = r_out_mode;
    assign o_target_id       = r_out_box.id;
    assign o_target_x        = r_out_box.pos.x;
    assign o_target_y        = r_out_box.pos.y;
    assign o_target_z        = r_out_box.pos.z;
    assign o_position_stable = r_out_stable;

endmodule

### dv/tthf_track_checker.sv
// tthf_track_checker: watches the channels of target_track_hysteresis_filter, predicts each
// frame result from its own copy of the mode, tracking and history state, and compares
// depends on tthf_pkg
module tthf_track_checker
    import tthf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic                    i_box_present,
    input  logic [ID_W-1:0]         i_box_id,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic                    i_frame_last,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [1:0]              i_target_mode,
    input  logic [ID_W-1:0]         i_target_id,
    input  logic signed [POS_W-1:0] i_target_x,
    input  logic signed [POS_W-1:0] i_target_y,
    input  logic signed [POS_W-1:0] i_target_z,
    input  logic                    i_position_stable,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [THR_W-1:0]        i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_frames,
    output int                      o_stable_frames,
    output logic [2:0]              o_modes_seen
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        t_mode           mode;
        logic [ID_W-1:0] id;
        t_pos            pos;
        logic            stable;
    } t_frame_result;

    logic [SWC_W-1:0] fast_count;
    logic [SWC_W-1:0] slow_count;
    logic [THR_W-1:0] stable_thr;

    t_mode            mode_q;
    logic [RUN_W-1:0] run_none;
    logic [RUN_W-1:0] run_single;
    logic [RUN_W-1:0] run_multi;
    t_box             tracked;
    t_box             candidate;
    logic [1:0]       frame_boxes;
    logic             id_matched;
    t_pos             hist [HISTORY_DEPTH];
    int               hist_fill;

    t_frame_result    frame_results_q [$];
    int               fails = 0;
    int               frames = 0;
    int               stable_frames = 0;
    logic [2:0]       modes_seen = '0;

    function automatic logic [RUN_W-1:0] run_step(input logic [RUN_W-1:0] r);
        return (r >= RUN_COUNT_MAX) ? r : r + 1'b1;
    endfunction

    function automatic longint unsigned axis_sq(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return longint'(d * d);
    endfunction

    function automatic longint unsigned span_sq(input t_pos a, input t_pos b);
        return axis_sq(a.x, b.x) + axis_sq(a.y, b.y) + axis_sq(a.z, b.z);
    endfunction

    // floor square root, one result bit at a time from the top
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = ROOT_W; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        fails++;
        if (fails <= PRINT_CAP)
            $display("[%0t] tthf mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    task automatic reset_model();
        fast_count  = FAST_SWITCH_RST;
        slow_count  = SLOW_SWITCH_RST;
        stable_thr  = STABLE_THR_RST;
        mode_q      = MODE_NONE;
        run_none    = '0;
        run_single  = '0;
        run_multi   = '0;
        tracked     = '0;
        candidate   = '0;
        frame_boxes = '0;
        id_matched  = 1'b0;
        hist_fill   = 0;
        for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] = '0;
        frame_results_q.delete();
    endtask

    // one accepted input item; a frame end queues the result it must give
    task automatic take_item();
        t_box            b;
        t_frame_result   res;
        longint unsigned d_old;
        longint unsigned d_mid;
        longint unsigned lim;
        if (i_box_present) begin
            b.id    = i_box_id;
            b.pos.x = i_pos_x;
            b.pos.y = i_pos_y;
            b.pos.z = i_pos_z;
            if (!id_matched) begin
                if (b.id == tracked.id) begin
                    candidate  = b;
                    id_matched = 1'b1;
                end else if (frame_boxes == 0 || b.id < candidate.id) begin
                    candidate = b;
                end
            end
            if (frame_boxes < 2) frame_boxes++;
        end
        if (!i_frame_last) return;

        case (frame_boxes)
            2'd0: begin
                run_none   = run_step(run_none);
                run_single = '0;
                run_multi  = '0;
            end
            2'd1: begin
                run_none   = '0;
                run_single = run_step(run_single);
                run_multi  = '0;
            end
            default: begin
                run_none   = '0;
                run_single = '0;
                run_multi  = run_step(run_multi);
            end
        endcase

        // hysteresis: fast count to leave no-target, slow count otherwise
        case (mode_q)
            MODE_NONE: begin
                if (run_single >= fast_count) mode_q = MODE_SINGLE;
                else if (run_multi >= fast_count) mode_q = MODE_MULTI;
            end
            MODE_SINGLE: begin
                if (run_none >= slow_count) mode_q = MODE_NONE;
                else if (run_multi >= slow_count) mode_q = MODE_MULTI;
            end
            default: begin
                if (run_single >= slow_count) mode_q = MODE_SINGLE;
                else if (run_none >= slow_count) mode_q = MODE_NONE;
            end
        endcase

        if (frame_boxes != 0) tracked = candidate;

        if (hist_fill >= HISTORY_DEPTH) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist[i] = hist[i + 1];
            hist[HISTORY_DEPTH - 1] = tracked.pos;
        end else begin
            hist[hist_fill] = tracked.pos;
            hist_fill++;
        end

        res.stable = 1'b0;
        if (hist_fill >= HISTORY_DEPTH) begin
            d_old = floor_root(span_sq(hist[2], hist[0]));
            d_mid = floor_root(span_sq(hist[2], hist[1]));
            lim   = stable_thr;
            lim   = lim * 2;
            res.stable = (d_old + d_mid > 0) && (d_old + d_mid < lim);
        end

        frame_boxes = '0;
        id_matched  = 1'b0;

        res.mode = mode_q;
        res.id   = tracked.id;
        res.pos  = tracked.pos;
        frame_results_q.insert(frame_results_q.size(), res);
    endtask

    task automatic check_result();
        t_frame_result want;
        frames++;
        if (frame_results_q.size() == 0) begin
            report_mismatch("result with no frame end pending", 0, i_target_id);
            return;
        end
        want = frame_results_q[0];
        frame_results_q.delete(0);
        modes_seen[want.mode] = 1'b1;
        if (want.stable) stable_frames++;
        if (i_target_mode !== want.mode)
            report_mismatch("target_mode", want.mode, i_target_mode);
        if (i_target_id !== want.id)
            report_mismatch("target_id", want.id, i_target_id);
        if (i_target_x !== want.pos.x)
            report_mismatch("target_x", $unsigned(want.pos.x), $unsigned(i_target_x));
        if (i_target_y !== want.pos.y)
            report_mismatch("target_y", $unsigned(want.pos.y), $unsigned(i_target_y));
        if (i_target_z !== want.pos.z)
            report_mismatch("target_z", $unsigned(want.pos.z), $unsigned(i_target_z));
        if (i_position_stable !== want.stable)
            report_mismatch("position_stable", want.stable, i_position_stable);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            // result first: a result on the same edge as its own frame end is early
            if (i_out_valid && i_out_ready) check_result();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FAST_SWITCH: fast_count = i_cfg_data[SWC_W-1:0];
                    CFG_SLOW_SWITCH: slow_count = i_cfg_data[SWC_W-1:0];
                    CFG_STABLE_THR:  stable_thr = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) take_item();
        end
        o_fail_count    = fails;
        o_pending       = frame_results_q.size();
        o_frames        = frames;
        o_stable_frames = stable_frames;
        o_modes_seen    = modes_seen;
    end

endmodule

### dv/target_track_hysteresis_filter_tb.sv
// target_track_hysteresis_filter_tb: stimulus and verdict for the target track filter
// drives frames of detection boxes and register settings; tthf_track_checker predicts
// depends on tthf_pkg, tthf_track_checker and target_track_hysteresis_filter
module target_track_hysteresis_filter_tb;
    import tthf_pkg::*;

    // index with no register behind it, writes there are ignored
    localparam logic [1:0] CFG_SPARE = 2'd3;
    // cycles a frame end may still be in flight after its result
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;
    // receiver hold-offs that fill the block and stall its input
    localparam int HOLD_AT_A     = 2000;
    localparam int HOLD_AT_B     = 9000;
    localparam int HOLD_CYCLES   = 300;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    in_valid;
    logic                    o_in_ready;
    logic                    box_present;
    logic [ID_W-1:0]         box_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    frame_last;
    logic                    o_out_valid;
    logic                    out_ready;
    logic [1:0]              o_target_mode;
    logic [ID_W-1:0]         o_target_id;
    logic signed [POS_W-1:0] o_target_x;
    logic signed [POS_W-1:0] o_target_y;
    logic signed [POS_W-1:0] o_target_z;
    logic                    o_position_stable;
    logic                    cfg_valid;
    logic                    o_cfg_ready;
    logic [1:0]              cfg_index;
    logic [THR_W-1:0]        cfg_data;

    int                      chk_fails;
    int                      chk_pending;
    int                      chk_frames;
    int                      chk_stable;
    logic [2:0]              chk_modes;

    // stimulus bookkeeping
    int items_sent;      // boxes and frame ends; idle items are not counted
    int settings_used;
    int burst_left;
    int frame_class;     // 0 no box, 1 one box, 2 several boxes
    int class_left;      // frames left in the current run of one class
    int base_x;
    int base_y;
    int base_z;

    target_track_hysteresis_filter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_box_present     (box_present),
        .i_box_id          (box_id),
        .i_pos_x           (pos_x),
        .i_pos_y           (pos_y),
        .i_pos_z           (pos_z),
        .i_frame_last      (frame_last),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_target_mode     (o_target_mode),
        .o_target_id       (o_target_id),
        .o_target_x        (o_target_x),
        .o_target_y        (o_target_y),
        .o_target_z        (o_target_z),
        .o_position_stable (o_position_stable),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    tthf_track_checker chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (o_in_ready),
        .i_box_present     (box_present),
        .i_box_id          (box_id),
        .i_pos_x           (pos_x),
        .i_pos_y           (pos_y),
        .i_pos_z           (pos_z),
        .i_frame_last      (frame_last),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .i_target_mode     (o_target_mode),
        .i_target_id       (o_target_id),
        .i_target_x        (o_target_x),
        .i_target_y        (o_target_y),
        .i_target_z        (o_target_z),
        .i_position_stable (o_position_stable),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (chk_fails),
        .o_pending         (chk_pending),
        .o_frames          (chk_frames),
        .o_stable_frames   (chk_stable),
        .o_modes_seen      (chk_modes)
    );

    // 12 unit clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #7200000;
        $display("timeout with %0d frame results still pending", chk_pending);
        $display("target_track_hysteresis_filter test failed");
        $finish;
    end

    // receiver: a stall rate that is redrawn as the run goes on, from never to most cycles,
    // plus two long hold-offs while the sender keeps offering items
    initial begin
        int cyc;
        int hold;
        int stall_pct;
        cyc       = 0;
        hold      = 0;
        stall_pct = 0;
        out_ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) hold = HOLD_CYCLES;
            if (cyc % 128 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // offer one item, called at a falling edge and back at one once it is taken;
    // valid drops here only in a gap between bursts
    task automatic send_item(input logic present, input logic [ID_W-1:0] id,
                             input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y,
                             input logic signed [POS_W-1:0] z, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        box_present <= present;
        box_id      <= id;
        pos_x       <= x;
        pos_y       <= y;
        pos_z       <= z;
        frame_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (present || last) items_sent++;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [THR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // upper data bits above a switch count are junk the block must drop
    task automatic write_settings(input logic [SWC_W-1:0] fast, input logic [SWC_W-1:0] slow,
                                  input logic [THR_W-1:0] thr, input logic [7:0] junk);
        cfg_write(CFG_FAST_SWITCH, {junk, fast});
        cfg_write(CFG_SLOW_SWITCH, {~junk, slow});
        cfg_write(CFG_STABLE_THR, thr);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // registers only change with no frame in flight; stop offering items first
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [POS_W-1:0] clamp_pos(input int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return POS_W'(v);
    endfunction

    function automatic logic signed [POS_W-1:0] near_pos(input int c, input int jit);
        int t;
        t = $urandom_range(0, 2 * jit);
        return clamp_pos(c + t - jit);
    endfunction

    // mostly a few small ids so the tracked target keeps turning up
    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return ID_W'($urandom_range(0, 4));
        if (r < 92) return ID_W'($urandom);
        return (r < 96) ? '0 : '1;
    endfunction

    // one frame; the box count follows runs of one class so the mode can switch,
    // with some frames breaking the run
    task automatic random_frame();
        int   nbox;
        int   jit;
        int   r;
        logic end_on_box;
        if (class_left == 0) begin
            frame_class = $urandom_range(0, 2);
            class_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                      : $urandom_range(1, 6);
        end
        class_left--;
        case (frame_class)
            0:       nbox = 0;
            1:       nbox = 1;
            default: nbox = $urandom_range(2, 5);
        endcase
        if ($urandom_range(0, 9) == 0) nbox = $urandom_range(0, 4);

        // the target mostly wanders, now and then it jumps or sits at an edge
        r = $urandom_range(0, 99);
        if (r < 4) begin
            base_x = $urandom_range(0, 65535) - 32768;
            base_y = $urandom_range(0, 65535) - 32768;
            base_z = $urandom_range(0, 65535) - 32768;
        end else if (r < 6) begin
            base_x = (r == 4) ? 32767 : -32768;
            base_y = (r == 4) ? -32768 : 32767;
            base_z = (r == 4) ? 32767 : -32768;
        end
        case ($urandom_range(0, 4))
            0:       jit = 0;
            1:       jit = 2;
            2:       jit = 40;
            3:       jit = 600;
            default: jit = 40000;
        endcase
        end_on_box = $urandom_range(0, 1);

        for (int k = 0; k < nbox; k++) begin
            if ($urandom_range(0, 11) == 0)
                send_item(1'b0, ID_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                          POS_W'($urandom), 1'b0);
            send_item(1'b1, pick_id(), near_pos(base_x, jit), near_pos(base_y, jit),
                      near_pos(base_z, jit), end_on_box && (k == nbox - 1));
        end
        if (nbox == 0 || !end_on_box)
            send_item(1'b0, ID_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                      POS_W'($urandom), 1'b1);
    endtask

    task automatic random_frames_until(input int target);
        while (items_sent < target) random_frame();
    endtask

    initial begin
        int waited;
        items_sent    = 0;
        settings_used = 1;
        burst_left    = 0;
        frame_class   = 0;
        class_left    = 0;
        base_x        = 0;
        base_y        = 0;
        base_z        = 0;
        i_rst_n     <= 1'b0;
        in_valid    <= 1'b0;
        box_present <= 1'b0;
        box_id      <= '0;
        pos_x       <= '0;
        pos_y       <= '0;
        pos_z       <= '0;
        frame_last  <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_FAST_SWITCH;
        cfg_data    <= '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames under the reset settings
        // empty frame before any box, then an idle item
        send_item(1'b0, 16'h1234, 16'h0055, 16'h00AA, 16'h0F0F, 1'b1);
        send_item(1'b0, 16'h4321, 16'h0AAA, 16'h0555, 16'h00F0, 1'b0);
        // id 0 matches the tracked id left by reset, though it comes second
        send_item(1'b1, 16'h0005, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        send_item(1'b1, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 1'b1);
        // single box with all-ones id at far positions, history now full
        send_item(1'b1, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0000, 1'b1);
        // two boxes with equal id: the first one wins; frame closed by an empty item
        send_item(1'b1, 16'd9, 16'sd10, 16'sd20, 16'sd30, 1'b0);
        send_item(1'b1, 16'd9, -16'sd10, -16'sd20, -16'sd30, 1'b0);
        send_item(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1);
        // tracked id 9 beats the smaller id 7
        send_item(1'b1, 16'd7, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_item(1'b1, 16'd9, 16'sd12, 16'sd20, 16'sd30, 1'b1);
        // three equal positions: zero distance is not stable
        send_item(1'b1, 16'd9, 16'sd12, 16'sd20, 16'sd30, 1'b1);
        send_item(1'b1, 16'd9, 16'sd12, 16'sd20, 16'sd30, 1'b1);
        // small move, stable under the reset threshold
        send_item(1'b1, 16'd9, 16'sd15, 16'sd24, 16'sd30, 1'b1);
        // frame with no box keeps the target and repeats its position
        send_item(1'b0, 16'h5555, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        send_item(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        // tracked id absent: smallest id taken
        send_item(1'b1, 16'd3, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_item(1'b1, 16'd2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        random_frames_until(170);

        // zero switch counts and zero threshold
        wait_idle();
        write_settings(8'd0, 8'd0, 16'd0, 8'($urandom));
        random_frames_until(340);

        // largest counts and threshold; a long single-box run saturates its counter
        wait_idle();
        write_settings(8'd255, 8'd255, 16'hFFFF, 8'($urandom));
        for (int f = 0; f < 262; f++)
            send_item(1'b1, 16'd3, near_pos(base_x, 30), near_pos(base_y, 30),
                      near_pos(base_z, 30), 1'b1);
        random_frames_until(640);

        // a write to the unused index, then a fast mode with a tight threshold
        wait_idle();
        cfg_write(CFG_SPARE, THR_W'($urandom));
        write_settings(8'd1, 8'd3, 16'd50, 8'($urandom));
        random_frames_until(800);

        wait_idle();
        write_settings(SWC_W'($urandom_range(1, 6)), SWC_W'($urandom_range(1, 8)),
                       THR_W'($urandom_range(1, 400)), 8'($urandom));
        random_frames_until(950);
        in_valid <= 1'b0;

        waited = 0;
        while (chk_pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("run covered %0d items under %0d register settings", items_sent,
                 settings_used);
        $display("%0d frame results checked, %0d stable, modes seen %b", chk_frames,
                 chk_stable, chk_modes);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("target_track_hysteresis_filter test passed");
        end else begin
            if (chk_pending != 0)
                $display("%0d frame results never arrived", chk_pending);
            $display("target_track_hysteresis_filter test failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/tthf_pkg.sv
rtl/target_track_hysteresis_filter.sv
dv/tthf_track_checker.sv
dv/target_track_hysteresis_filter_tb.sv
